### design/bpc_pkg.sv
package bpc_pkg;

  // Timer and limit widths
  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam int unsigned LIMIT_WIDTH     = 16;

  // Register reset values
  localparam logic [LIMIT_WIDTH-1:0] DEBOUNCE_RESET = 16'd10;
  localparam logic [LIMIT_WIDTH-1:0] SHORT_RESET    = 16'd100;
  localparam logic [LIMIT_WIDTH-1:0] LONG_RESET     = 16'd300;

  // APB register map
  localparam int unsigned PADDR_WIDTH = 4;
  localparam int unsigned PDATA_WIDTH = 32;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_SHORT    = 2'd1,
    REG_LONG     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_TAKE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_DEBOUNCE = 3'd1,
    PH_SHORT    = 3'd2,
    PH_LONG     = 3'd3,
    PH_WAIT     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] command;
    logic       pin_level;
  } in_word_t;

  typedef struct packed {
    logic       event_ready;
    logic [1:0] press_kind;
    logic [2:0] current_phase;
  } out_word_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] debounce_ticks;
    logic [LIMIT_WIDTH-1:0] short_ticks;
    logic [LIMIT_WIDTH-1:0] long_ticks;
  } cfg_t;

endpackage

### design/bpc_cfg_regs.sv
module bpc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bpc_pkg::PADDR_WIDTH-1:0]     paddr,
  input  logic [bpc_pkg::PDATA_WIDTH-1:0]     pwdata,
  output logic [bpc_pkg::PDATA_WIDTH-1:0]     prdata,
  output logic                                pready,
  output bpc_pkg::cfg_t                       cfg_o
);

  bpc_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        bpc_pkg::REG_DEBOUNCE: cfg_d.debounce_ticks = pwdata[bpc_pkg::LIMIT_WIDTH-1:0];
        bpc_pkg::REG_SHORT:    cfg_d.short_ticks    = pwdata[bpc_pkg::LIMIT_WIDTH-1:0];
        bpc_pkg::REG_LONG:     cfg_d.long_ticks     = pwdata[bpc_pkg::LIMIT_WIDTH-1:0];
        default: ;  // drop writes beyond the map
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      bpc_pkg::REG_DEBOUNCE: prdata = bpc_pkg::PDATA_WIDTH'(cfg_q.debounce_ticks);
      bpc_pkg::REG_SHORT:    prdata = bpc_pkg::PDATA_WIDTH'(cfg_q.short_ticks);
      bpc_pkg::REG_LONG:     prdata = bpc_pkg::PDATA_WIDTH'(cfg_q.long_ticks);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= bpc_pkg::DEBOUNCE_RESET;
      cfg_q.short_ticks    <= bpc_pkg::SHORT_RESET;
      cfg_q.long_ticks     <= bpc_pkg::LONG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/bpc_core.sv
module bpc_core #(
  parameter int unsigned TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  bpc_pkg::in_word_t    word_i,
  input  bpc_pkg::cfg_t        cfg_i,
  output bpc_pkg::out_word_t   word_o
);

  localparam int unsigned CmpWidth =
    (TIMER_WIDTH > bpc_pkg::LIMIT_WIDTH) ? TIMER_WIDTH : bpc_pkg::LIMIT_WIDTH;

  bpc_pkg::phase_e                  phase_q, phase_d;
  bpc_pkg::kind_e                   pending_q, pending_d;
  logic [TIMER_WIDTH-1:0]           tick_q, tick_d, tick_inc;
  logic [bpc_pkg::LIMIT_WIDTH-1:0]  limit_q, limit_d;
  logic                             at_limit;
  logic                             released;
  logic                             ready;
  bpc_pkg::kind_e                   kind;

  assign released = word_i.pin_level;
  // Saturate the timer at all ones
  assign tick_inc = (tick_q == {TIMER_WIDTH{1'b1}}) ? tick_q : tick_q + TIMER_WIDTH'(1);
  assign at_limit = CmpWidth'(tick_inc) >= CmpWidth'(limit_q);

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    tick_d    = tick_q;
    limit_d   = limit_q;
    ready     = 1'b0;
    kind      = bpc_pkg::KIND_NONE;
    unique case (word_i.command)
      bpc_pkg::CMD_TICK: begin
        tick_d = tick_inc;
        unique case (phase_q)
          bpc_pkg::PH_IDLE: begin
            if (!released) begin
              phase_d = bpc_pkg::PH_DEBOUNCE;
              tick_d  = '0;
              limit_d = cfg_i.debounce_ticks;
            end
          end
          bpc_pkg::PH_DEBOUNCE: begin
            if (at_limit) begin
              if (!released) begin
                phase_d = bpc_pkg::PH_SHORT;
                tick_d  = '0;
                limit_d = cfg_i.short_ticks;
              end else begin
                phase_d = bpc_pkg::PH_IDLE;
              end
            end
          end
          bpc_pkg::PH_SHORT: begin
            if (released) begin
              phase_d   = bpc_pkg::PH_IDLE;
              pending_d = bpc_pkg::KIND_SHORT;
            end else if (at_limit) begin
              phase_d = bpc_pkg::PH_LONG;
              tick_d  = '0;
              limit_d = cfg_i.long_ticks;
            end
          end
          bpc_pkg::PH_LONG: begin
            if (released) begin
              phase_d   = bpc_pkg::PH_IDLE;
              pending_d = bpc_pkg::KIND_SHORT;
            end else if (at_limit) begin
              phase_d   = bpc_pkg::PH_WAIT;
              pending_d = bpc_pkg::KIND_LONG;
            end
          end
          default: begin
            // wait-for-release, and unused codes behave the same
            phase_d = released ? bpc_pkg::PH_IDLE : bpc_pkg::PH_WAIT;
          end
        endcase
      end
      bpc_pkg::CMD_TAKE: begin
        if (pending_q != bpc_pkg::KIND_NONE) begin
          ready     = 1'b1;
          kind      = pending_q;
          pending_d = bpc_pkg::KIND_NONE;
        end
      end
      bpc_pkg::CMD_CLEAR: begin
        phase_d = bpc_pkg::PH_WAIT;
        tick_d  = '0;
      end
      default: ;  // ignore the unused command
    endcase
  end

  assign word_o.event_ready   = ready;
  assign word_o.press_kind    = kind;
  assign word_o.current_phase = phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= bpc_pkg::PH_WAIT;
      pending_q <= bpc_pkg::KIND_NONE;
      tick_q    <= '0;
      limit_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pending_q <= pending_d;
      tick_q    <= tick_d;
      limit_q   <= limit_d;
    end
  end

endmodule

### design/button_press_classifier.sv
// Path: an accepted word waits in the input register; its result then lands in the
//   result register and shows at out_valid_o. Throughput: one word per cycle while
//   out_stall_i is low, set by the phase update between these registers.
// Reset (rst_ni low, asynchronous): both pipeline registers empty, phase
//   wait-for-release, timer and limit zero, no pending event, limits 10/100/300.
module button_press_classifier #(
  parameter int unsigned TIMER_WIDTH = bpc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  bpc_pkg::in_word_t                in_word_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output bpc_pkg::out_word_t               out_word_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bpc_pkg::PADDR_WIDTH-1:0]  paddr,
  input  logic [bpc_pkg::PDATA_WIDTH-1:0]  pwdata,
  output logic [bpc_pkg::PDATA_WIDTH-1:0]  prdata,
  output logic                             pready
);

  // Input register stage
  logic               in_valid_q, in_valid_d;
  bpc_pkg::in_word_t  in_word_q;
  // Result register stage
  logic               out_valid_q, out_valid_d;
  bpc_pkg::out_word_t out_word_q;

  bpc_pkg::cfg_t      cfg;
  bpc_pkg::out_word_t result;
  logic               advance;
  logic               load_in;

  bpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held word into the result register when the result slot is
  // free or being drained this cycle; the phase state updates on the same edge.
  assign advance = in_valid_q && (!out_valid_q || !out_stall_i);

  // Take a new word whenever the input register is empty or moving on.
  assign in_stall_o = in_valid_q && !advance;
  assign load_in    = in_valid_i && !in_stall_o;

  bpc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .word_i (in_word_q),
    .cfg_i  (cfg),
    .word_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (load_in) begin
      in_valid_d = 1'b1;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold unless a new word lands
  always_ff @(posedge clk_i) begin
    if (load_in) begin
      in_word_q <= in_word_i;
    end
    if (advance) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
